>>> hw/rtl/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

    localparam int CANVAS_WIDTH_MAX_DEF  = 256;
    localparam int CANVAS_HEIGHT_MAX_DEF = 256;
    localparam int PALETTE_DEPTH_DEF     = 256;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

    localparam logic [2:0] DISPOSE_BACKGROUND = 3'd2;
    localparam logic [7:0] ALPHA_OPAQUE       = 8'hff;

    typedef enum logic [1:0] {
        FUNC_PALETTE = 2'd0,
        FUNC_FRAME   = 2'd1,
        FUNC_RASTER  = 2'd2,
        FUNC_READ    = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [7:0]  graphics_flags;
        logic [7:0]  transparent_index;
        logic        first_frame;
        logic [7:0]  color_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        in_range;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/pfc_palette_ram.sv
`default_nettype none

module pfc_palette_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [23:0]       i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [23:0]            o_rdata
);

    logic [23:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pfc_canvas_ram.sv
`default_nettype none

module pfc_canvas_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [31:0]       i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [31:0]            o_rdata
);

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/palette_frame_compositor.sv
`default_nettype none

// Palette frame compositor. Palette writes, raster indices and canvas reads
// are taken one per clock while o_busy is low. A canvas read returns its
// word on o_result, marked by o_result_valid, in the cycle right after the
// read is accepted; the receiver cannot stall and must take it then. A frame
// start that clears the canvas (first frame, or disposal code 2) holds o_busy
// high while the clear walks the canvas memory one word per cycle through its
// single write port. No clear runs after reset, so canvas words are undefined
// until the first clearing frame. Configuration writes are always taken
// (o_cfg_ready is high) and must only be issued while the block is idle.
module palette_frame_compositor #(
    parameter int CANVAS_WIDTH_MAX  = pfc_pkg::CANVAS_WIDTH_MAX_DEF,
    parameter int CANVAS_HEIGHT_MAX = pfc_pkg::CANVAS_HEIGHT_MAX_DEF,
    parameter int PALETTE_DEPTH     = pfc_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire pfc_pkg::t_in_item                  i_cmd,
    output logic                                    o_busy,
    output logic                                    o_result_valid,
    output pfc_pkg::t_out_item                      o_result,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [pfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [31:0]                        i_cfg_data
);

    import pfc_pkg::*;

    localparam int CANVAS_DEPTH = CANVAS_WIDTH_MAX * CANVAS_HEIGHT_MAX;
    localparam int ADDR_W       = $clog2(CANVAS_DEPTH);
    localparam int X_W          = $clog2(CANVAS_WIDTH_MAX);
    localparam int Y_W          = $clog2(CANVAS_HEIGHT_MAX);
    localparam int PIDX_W       = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [16:0] CW17 = 17'(CANVAS_WIDTH_MAX);
    localparam logic [16:0] CH17 = 17'(CANVAS_HEIGHT_MAX);
    localparam logic [8:0]  PD9  = 9'(PALETTE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CANVAS_DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(CANVAS_WIDTH_MAX);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_CLEAR = 2'b10
    } t_state;

    t_state r_state;

    logic [8:0]  r_screen_w;
    logic [8:0]  r_screen_h;
    logic [31:0] r_background;

    logic [15:0] r_origin_x;
    logic [15:0] r_origin_y;
    logic [15:0] r_frame_w;
    logic [15:0] r_frame_h;
    logic [15:0] r_col;
    logic [15:0] r_row;
    logic        r_key_en;
    logic [7:0]  r_key_idx;

    logic [ADDR_W-1:0] r_clr_addr;

    // pixel write waiting for its palette color
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_pal_oor;

    logic        r_rd_valid;
    logic        r_rd_in_range;
    logic        r_fwd;
    logic [31:0] r_fwd_data;

    logic        accept;
    logic [16:0] sw;
    logic [16:0] sh;
    logic [16:0] col17;
    logic [16:0] row17;
    logic [16:0] dx;
    logic [16:0] dy;
    logic        frame_ok;
    logic        key_hit;
    logic        draw;
    logic        clear_req;
    logic        rd_in_range;
    logic [16:0] px17;
    logic [16:0] py17;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              pal_in_range;
    logic [23:0]       pal_q;
    logic [31:0]       pix_data;
    logic [31:0]       cv_q;
    logic              cv_we;
    logic [ADDR_W-1:0] cv_waddr;
    logic [31:0]       cv_wdata;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state == ST_CLEAR);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        sw = (17'(r_screen_w) > CW17) ? CW17 : 17'(r_screen_w);
        sh = (17'(r_screen_h) > CH17) ? CH17 : 17'(r_screen_h);
    end

    assign col17    = 17'(r_col);
    assign row17    = 17'(r_row);
    assign dx       = 17'(r_origin_x) + col17;
    assign dy       = 17'(r_origin_y) + row17;
    assign frame_ok = (r_frame_w != 16'd0) && (r_row < r_frame_h);
    assign key_hit  = r_key_en && (i_cmd.color_index == r_key_idx);
    assign draw     = frame_ok && (col17 < sw) && (row17 < sh) && !key_hit
                      && (dx < sw) && (dy < sh);
    assign draw_addr = ADDR_W'(dy[Y_W-1:0]) * ROW_STRIDE + ADDR_W'(dx[X_W-1:0]);

    assign px17        = 17'(i_cmd.pos_x);
    assign py17        = 17'(i_cmd.pos_y);
    assign rd_in_range = (px17 < sw) && (py17 < sh);
    assign rd_addr     = ADDR_W'(i_cmd.pos_y[Y_W-1:0]) * ROW_STRIDE
                         + ADDR_W'(i_cmd.pos_x[X_W-1:0]);

    assign pal_in_range = ({1'b0, i_cmd.color_index} < PD9);
    assign clear_req    = i_cmd.first_frame
                          || (i_cmd.graphics_flags[4:2] == DISPOSE_BACKGROUND);

    assign pix_data = {ALPHA_OPAQUE, (r_pal_oor ? 24'h0 : pal_q)};

    pfc_palette_ram #(
        .DEPTH  (PALETTE_DEPTH),
        .ADDR_W (PIDX_W)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (accept && (i_cmd.func == FUNC_PALETTE) && pal_in_range),
        .i_waddr (i_cmd.color_index[PIDX_W-1:0]),
        .i_wdata ({i_cmd.blue, i_cmd.green, i_cmd.red}),
        .i_re    (accept && (i_cmd.func == FUNC_RASTER)),
        .i_raddr (i_cmd.color_index[PIDX_W-1:0]),
        .o_rdata (pal_q)
    );

    always_comb begin
        if (r_state == ST_CLEAR) begin
            cv_we    = 1'b1;
            cv_waddr = r_clr_addr;
            cv_wdata = r_background;
        end else begin
            cv_we    = r_wr_pend;
            cv_waddr = r_wr_addr;
            cv_wdata = pix_data;
        end
    end

    pfc_canvas_ram #(
        .DEPTH  (CANVAS_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (cv_we),
        .i_waddr (cv_waddr),
        .i_wdata (cv_wdata),
        .i_re    (accept && (i_cmd.func == FUNC_READ)),
        .i_raddr (rd_addr),
        .o_rdata (cv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w   <= 9'd256;
            r_screen_h   <= 9'd256;
            r_background <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_w   <= i_cfg_data[8:0];
                CFG_SCREEN_HEIGHT: r_screen_h   <= i_cfg_data[8:0];
                CFG_BACKGROUND:    r_background <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_clr_addr <= '0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_frame_w  <= '0;
            r_frame_h  <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_key_en   <= 1'b0;
            r_key_idx  <= '0;
            r_wr_pend  <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_wr_pend  <= 1'b0;
            r_rd_valid <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (accept) begin
                        unique case (i_cmd.func)
                            FUNC_FRAME: begin
                                r_origin_x <= i_cmd.pos_x;
                                r_origin_y <= i_cmd.pos_y;
                                r_frame_w  <= i_cmd.frame_width;
                                r_frame_h  <= i_cmd.frame_height;
                                r_col      <= '0;
                                r_row      <= '0;
                                r_key_en   <= i_cmd.graphics_flags[0];
                                r_key_idx  <= i_cmd.transparent_index;
                                if (clear_req) begin
                                    r_state    <= ST_CLEAR;
                                    r_clr_addr <= '0;
                                end
                            end
                            FUNC_RASTER: begin
                                r_wr_pend <= draw;
                                if (frame_ok) begin
                                    if ((col17 + 17'd1) >= 17'(r_frame_w)) begin
                                        r_col <= '0;
                                        r_row <= r_row + 16'd1;
                                    end else begin
                                        r_col <= r_col + 16'd1;
                                    end
                                end
                            end
                            FUNC_READ: begin
                                r_rd_valid <= 1'b1;
                            end
                            FUNC_PALETTE: ;
                            default: ;
                        endcase
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_cmd.func == FUNC_RASTER)) begin
            r_wr_addr <= draw_addr;
            r_pal_oor <= !pal_in_range;
        end
        if (accept && (i_cmd.func == FUNC_READ)) begin
            r_rd_in_range <= rd_in_range;
            // the pixel written at this edge is not yet visible to the read
            r_fwd         <= r_wr_pend && (r_wr_addr == rd_addr);
            r_fwd_data    <= pix_data;
        end
    end

    assign o_result_valid = r_rd_valid;

    always_comb begin
        o_result.in_range = r_rd_in_range;
        if (!r_rd_in_range) begin
            o_result.pixel_value = 32'd0;
        end else if (r_fwd) begin
            o_result.pixel_value = r_fwd_data;
        end else begin
            o_result.pixel_value = cv_q;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pfc_checker.sv
`default_nettype none

module pfc_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire pfc_pkg::t_in_item             i_cmd,
    input  wire logic                          o_busy,
    input  wire logic                          o_result_valid,
    input  wire pfc_pkg::t_out_item            o_result
);

    import pfc_pkg::*;

    logic read_acc;
    logic frame_acc;

    assign read_acc  = i_start && !o_busy && (i_cmd.func == FUNC_READ);
    assign frame_acc = i_start && !o_busy && (i_cmd.func == FUNC_FRAME);

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_acc |=> o_result_valid)
        else $error("accepted read produced no result");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(read_acc))
        else $error("result without a preceding read");

    a_outside_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.in_range) |-> (o_result.pixel_value == 32'd0))
        else $error("out-of-range read returned nonzero word");

    a_busy_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(frame_acc))
        else $error("busy raised without a frame start");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && $past(o_busy)) |-> !o_result_valid)
        else $error("result during canvas clear");

endmodule

bind palette_frame_compositor pfc_checker u_pfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .i_cmd          (i_cmd),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire

>>> sim/tb_palette_frame_compositor.sv
`timescale 1ns / 100ps

module tb_palette_frame_compositor;
    import pfc_pkg::*;

    localparam int CANVAS_W  = CANVAS_WIDTH_MAX_DEF;
    localparam int CANVAS_H  = CANVAS_HEIGHT_MAX_DEF;
    localparam int PALETTE_N = PALETTE_DEPTH_DEF;

    // Canvas predictor plus the queue of canvas words still owed by the block
    class canvas_scoreboard;
        logic [23:0] palette_rgb [PALETTE_N];
        bit          palette_loaded [PALETTE_N];
        logic [31:0] canvas_word [CANVAS_W * CANVAS_H];
        logic [15:0] org_x = '0;
        logic [15:0] org_y = '0;
        logic [15:0] frm_w = '0;
        logic [15:0] frm_h = '0;
        int unsigned col_pos = 0;
        int unsigned row_pos = 0;
        bit          key_on = 1'b0;
        logic [7:0]  key_val = '0;
        logic [8:0]  scr_w = 9'd256;
        logic [8:0]  scr_h = 9'd256;
        logic [31:0] fill_word = '0;
        t_out_item   expected_reads[$];
        int          mismatches = 0;

        function int unsigned cols_visible();
            return (scr_w > CANVAS_W) ? CANVAS_W : scr_w;
        endfunction

        function int unsigned rows_visible();
            return (scr_h > CANVAS_H) ? CANVAS_H : scr_h;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_SCREEN_WIDTH:  scr_w = data[8:0];
                CFG_SCREEN_HEIGHT: scr_h = data[8:0];
                CFG_BACKGROUND:    fill_word = data;
                default: ;
            endcase
        endfunction

        function void note_command(t_in_item c);
            int unsigned sw, sh, col, row, dx, dy;
            t_out_item   rd;
            sw = cols_visible();
            sh = rows_visible();
            case (c.func)
                FUNC_PALETTE: begin
                    if (c.color_index < PALETTE_N) begin
                        palette_rgb[c.color_index] = {c.blue, c.green, c.red};
                        palette_loaded[c.color_index] = 1'b1;
                    end
                end
                FUNC_FRAME: begin
                    org_x   = c.pos_x;
                    org_y   = c.pos_y;
                    frm_w   = c.frame_width;
                    frm_h   = c.frame_height;
                    col_pos = 0;
                    row_pos = 0;
                    key_on  = c.graphics_flags[0];
                    key_val = c.transparent_index;
                    if (c.first_frame || c.graphics_flags[4:2] == DISPOSE_BACKGROUND) begin
                        foreach (canvas_word[i]) canvas_word[i] = fill_word;
                    end
                end
                FUNC_RASTER: begin
                    col = col_pos;
                    row = row_pos;
                    // drop indices past the end of the frame
                    if (frm_w != 0 && row < frm_h) begin
                        if (col < sw && row < sh && !(key_on && c.color_index == key_val)) begin
                            dx = org_x + col;
                            dy = org_y + row;
                            if (dx < sw && dy < sh) begin
                                canvas_word[dy * CANVAS_W + dx] = {ALPHA_OPAQUE,
                                    (c.color_index < PALETTE_N) ?
                                    palette_rgb[c.color_index] : 24'h0};
                            end
                        end
                        if (col + 1 >= frm_w) begin
                            col_pos = 0;
                            row_pos = row + 1;
                        end else begin
                            col_pos = col + 1;
                        end
                    end
                end
                FUNC_READ: begin
                    rd = '0;
                    if (c.pos_x < sw && c.pos_y < sh) begin
                        rd.pixel_value = canvas_word[c.pos_y * CANVAS_W + c.pos_x];
                        rd.in_range    = 1'b1;
                    end
                    expected_reads.push_back(rd);
                end
                default: ;
            endcase
        endfunction

        function void check_read(t_out_item got);
            t_out_item want;
            if (expected_reads.size() == 0) begin
                $error("unexpected result: pixel_value %h in_range %b",
                       got.pixel_value, got.in_range);
                mismatches++;
                return;
            end
            want = expected_reads.pop_front();
            if (got.pixel_value !== want.pixel_value) begin
                $error("pixel_value: expected %h, actual %h", want.pixel_value, got.pixel_value);
                mismatches++;
            end
            if (got.in_range !== want.in_range) begin
                $error("in_range: expected %b, actual %b", want.in_range, got.in_range);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    t_in_item             i_cmd = '0;
    logic                 o_busy;
    logic                 o_result_valid;
    t_out_item            o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    canvas_scoreboard sb;
    int               idle_pct = 0;
    int               items_sent = 0;

    always #4 i_clk = ~i_clk;

    palette_frame_compositor u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_cmd          (i_cmd),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) sb.check_read(o_result);
    end

    function automatic t_in_item any_item(t_func f);
        logic [127:0] noise;
        t_in_item     c;
        noise = {$urandom, $urandom, $urandom, $urandom};
        c = noise[$bits(t_in_item)-1:0];
        c.func = f;
        return c;
    endfunction

    function automatic t_in_item palette_cmd(logic [7:0] idx, logic [7:0] r,
                                             logic [7:0] g, logic [7:0] b);
        t_in_item c;
        c = any_item(FUNC_PALETTE);
        c.color_index = idx;
        c.red         = r;
        c.green       = g;
        c.blue        = b;
        return c;
    endfunction

    function automatic t_in_item frame_cmd(logic [15:0] x, logic [15:0] y,
                                           logic [15:0] w, logic [15:0] h,
                                           logic [7:0] flags, logic [7:0] key, bit first);
        t_in_item c;
        c = any_item(FUNC_FRAME);
        c.pos_x             = x;
        c.pos_y             = y;
        c.frame_width       = w;
        c.frame_height      = h;
        c.graphics_flags    = flags;
        c.transparent_index = key;
        c.first_frame       = first;
        return c;
    endfunction

    function automatic t_in_item raster_cmd(logic [7:0] idx);
        t_in_item c;
        c = any_item(FUNC_RASTER);
        c.color_index = idx;
        return c;
    endfunction

    function automatic t_in_item read_cmd(logic [15:0] x, logic [15:0] y);
        t_in_item c;
        c = any_item(FUNC_READ);
        c.pos_x = x;
        c.pos_y = y;
        return c;
    endfunction

    // Frame start that leaves the canvas alone
    function automatic t_in_item no_clear(t_in_item c);
        c.first_frame = 1'b0;
        if (c.graphics_flags[4:2] == DISPOSE_BACKGROUND)
            c.graphics_flags[4:2] = 3'($urandom_range(3, 7));
        return c;
    endfunction

    function automatic logic [7:0] pick_loaded();
        logic [7:0] v;
        v = 8'($urandom);
        while (!sb.palette_loaded[v]) v = 8'($urandom);
        return v;
    endfunction

    // Raster index: never point at an unloaded palette slot unless it is keyed out
    function automatic logic [7:0] raster_pick();
        if (sb.key_on && $urandom_range(0, 3) == 0) return sb.key_val;
        return pick_loaded();
    endfunction

    function automatic int unsigned origin_pick(int unsigned limit);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 65535);
            1: return (limit > 3) ? limit - $urandom_range(1, 3) : 0;
            default: return (limit > 0) ? $urandom_range(0, limit - 1) : $urandom_range(0, 5);
        endcase
    endfunction

    function automatic logic [15:0] read_coord(int unsigned base, int unsigned limit);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return (limit > 0) ? 16'($urandom_range(0, limit - 1)) : 16'($urandom_range(0, 3));
            default: return 16'(base + $urandom_range(0, 9));
        endcase
    endfunction

    task automatic send(input t_in_item c);
        // draw idle gaps in a loop so idle_pct is the share of idle cycles
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
        sb.note_command(c);
        items_sent++;
    endtask

    // Leaves i_cfg_valid high; the caller drops it after the last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.load_register(idx, data);
    endtask

    // Hold until every read has returned and any canvas clear has finished
    task automatic wait_quiet();
        i_start <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (sb.expected_reads.size() != 0 || o_busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic configure(input int seg);
        logic [8:0]  w, h;
        logic [31:0] fill;
        fill = $urandom;
        case (seg)
            0: begin w = 9'd256; h = 9'd256; end
            1: begin w = 9'd1; h = 9'd1; fill = 32'hffff_ffff; end
            2: begin w = 9'd0; h = 9'($urandom_range(1, 256)); fill = '0; end
            3: begin w = 9'd511; h = 9'd300; end
            4: begin w = 9'd17; h = 9'd9; end
            default: begin w = 9'($urandom_range(1, 256)); h = 9'($urandom_range(1, 256)); end
        endcase
        write_register(CFG_SCREEN_WIDTH, {23'($urandom), w});
        write_register(CFG_SCREEN_HEIGHT, {23'($urandom), h});
        write_register(CFG_BACKGROUND, fill);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic play_frame(input bit clearing);
        t_in_item    c;
        int unsigned sw, sh, fw, fh, ox, oy;
        longint      n;
        repeat ($urandom_range(0, 3))
            send(palette_cmd(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
        sw = sb.cols_visible();
        sh = sb.rows_visible();
        case ($urandom_range(0, 9))
            0: begin fw = 0; fh = $urandom_range(0, 3); end
            1: begin fw = $urandom_range(1, 3); fh = 0; end
            2: begin fw = $urandom_range(1, 65535); fh = $urandom_range(1, 65535); end
            default: begin fw = $urandom_range(1, 8); fh = $urandom_range(1, 6); end
        endcase
        ox = origin_pick(sw);
        oy = origin_pick(sh);
        c = frame_cmd(16'(ox), 16'(oy), 16'(fw), 16'(fh), 8'($urandom), pick_loaded(), 1'b0);
        if (!clearing) c = no_clear(c);
        else if ($urandom_range(0, 1) == 1) c.first_frame = 1'b1;
        else c.graphics_flags[4:2] = DISPOSE_BACKGROUND;
        send(c);

        n = longint'(fw) * longint'(fh);
        if (n > 40) n = 40;
        // run past the last pixel now and then
        if ($urandom_range(0, 5) == 0) n += $urandom_range(1, 3);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) send(read_cmd(read_coord(ox, sw), read_coord(oy, sh)));
            send(raster_cmd(raster_pick()));
        end
        repeat ($urandom_range(2, 5)) send(read_cmd(read_coord(ox, sw), read_coord(oy, sh)));
    endtask

    initial begin
        t_in_item c;
        int       stop_at;
        sb = new;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_register(CFG_BACKGROUND, $urandom);
        i_cfg_valid <= 1'b0;

        idle_pct = 21;
        send(raster_cmd(8'h00));
        send(palette_cmd(8'h00, 8'h00, 8'h00, 8'h00));
        send(palette_cmd(8'hff, 8'hff, 8'hff, 8'hff));
        send(palette_cmd(8'h5a, 8'h12, 8'h34, 8'h56));
        send(frame_cmd(16'd0, 16'd0, 16'd2, 16'd2, 8'h00, 8'h00, 1'b1));
        send(raster_cmd(8'h00));
        send(raster_cmd(8'hff));
        send(raster_cmd(8'h5a));
        send(raster_cmd(8'hff));
        send(raster_cmd(8'h00));
        send(read_cmd(16'd0, 16'd0));
        send(read_cmd(16'd1, 16'd1));
        send(read_cmd(16'd2, 16'd0));
        send(read_cmd(16'd256, 16'd0));
        send(read_cmd(16'hffff, 16'hffff));
        // dispose to background, keyed, straddling the bottom-right corner
        send(frame_cmd(16'd254, 16'd255, 16'd3, 16'd2, 8'h09, 8'h5a, 1'b0));
        send(raster_cmd(8'h5a));
        send(raster_cmd(8'hff));
        send(raster_cmd(8'h00));
        send(raster_cmd(8'h5a));
        send(read_cmd(16'd254, 16'd255));
        send(read_cmd(16'd255, 16'd255));
        send(frame_cmd(16'd0, 16'd0, 16'd0, 16'd3, 8'he2, 8'h00, 1'b0));
        send(raster_cmd(8'hff));
        send(read_cmd(16'd0, 16'd0));

        for (int seg = 0; seg < 6; seg++) begin
            wait_quiet();
            configure(seg);
            case (seg % 3)
                0: idle_pct = 21;
                1: idle_pct = 73;
                default: idle_pct = 0;
            endcase
            stop_at = items_sent + 70;
            play_frame(1'b1);
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 4) == 0) begin
                    c = any_item(t_func'($urandom_range(0, 3)));
                    if (c.func == FUNC_RASTER) c.color_index = raster_pick();
                    if (c.func == FUNC_FRAME) c = no_clear(c);
                    send(c);
                end else begin
                    play_frame(1'b0);
                end
            end
        end

        wait_quiet();
        repeat (4) @(posedge i_clk);
        if (sb.expected_reads.size() != 0) begin
            $error("%0d canvas reads never returned", sb.expected_reads.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_palette_ram.sv
hw/rtl/pfc_canvas_ram.sv
hw/rtl/palette_frame_compositor.sv
hw/rtl/pfc_checker.sv
sim/tb_palette_frame_compositor.sv
